/* hw/rtl/stream_duplicate_remover_macros.svh */
// Assertion macros shared by the duplicate remover RTL
`ifndef STREAM_DUPLICATE_REMOVER_MACROS_SVH
`define STREAM_DUPLICATE_REMOVER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SDR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define SDR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sdr_pkg.sv */
// Types and constants shared by the duplicate remover modules
package sdr_pkg;

	localparam int DATA_W = 32;
	localparam int KEPT_W = 9;

	// Input transfer payload
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} sdr_in_t;

	// Output transfer payload
	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic                     keep;
		logic [KEPT_W-1:0]        kept_count;
		logic                     overflow;
		logic                     end_of_array;
	} sdr_out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic scan_en;
		logic commit;
	} sdr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;
	} sdr_sts_t;

endpackage

/* hw/rtl/stream_duplicate_remover.sv */
// Top level of the stream duplicate remover
//
// Input channel (in_valid/in_ready/in_data) carries one array element and its
// last flag per transfer. Output channel (out_valid/out_ready/out_data) returns
// exactly one result per element: the value, keep (first occurrence stored),
// the running count of kept values, overflow (new value met a full table) and
// end_of_array. On the last element the count is the array's final length and
// the table is emptied for the next array.
// Each element is scanned against the stored values and then committed; the
// result appears the cycle after commit.
// Elements are handled one at a time: a new element is accepted only after the
// last one is committed. The scan is set by the single read port of the value
// memory, which is scanned one entry per cycle.
// Reset clears the count and control state; the memory needs no clearing.
// A stalled receiver holds the finished result in the output register; the next
// element is still accepted and scanned, and waits only at the commit step.
module stream_duplicate_remover #(
	parameter int MAX_DISTINCT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sdr_pkg::sdr_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sdr_pkg::sdr_out_t out_data
);

	sdr_pkg::sdr_cmd_t cmd;
	sdr_pkg::sdr_sts_t sts;

	sdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sdr_datapath #(
		.MAX_DISTINCT (MAX_DISTINCT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

/* hw/rtl/sdr_datapath.sv */
// Datapath: value table memory, scan counter, match flag, count and result register
`include "stream_duplicate_remover_macros.svh"

module sdr_datapath #(
	parameter int MAX_DISTINCT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sdr_pkg::sdr_in_t  in_data,
	input  sdr_pkg::sdr_cmd_t cmd,
	output sdr_pkg::sdr_sts_t sts,
	output sdr_pkg::sdr_out_t out_data
);

	localparam int CW = $clog2(MAX_DISTINCT + 1);
	localparam int AW = $clog2(MAX_DISTINCT);

	logic signed [sdr_pkg::DATA_W-1:0] mem [MAX_DISTINCT];

	logic signed [sdr_pkg::DATA_W-1:0] val_q;
	logic                              last_q;
	logic signed [sdr_pkg::DATA_W-1:0] rd_q;
	logic                              rd_vld_q;
	logic                              hit_q;
	logic [CW-1:0]                     idx_q;
	logic [CW-1:0]                     cnt_q;
	sdr_pkg::sdr_out_t                 out_q;

	logic                              issue;
	logic                              is_new;
	logic                              room;
	logic                              keep_w;
	logic                              ovf_w;
	logic [CW-1:0]                     cnt_nxt;
	logic [CW+sdr_pkg::KEPT_W-1:0]     kept_wide;

	// Read the next stored entry while the scan has entries left and no match
	assign issue = cmd.scan_en && !hit_q && (idx_q != cnt_q);

	// Scan ends on a match, or once every entry is read and compared
	assign sts.scan_done = hit_q || ((idx_q == cnt_q) && !rd_vld_q);

	// Keep-first decision
	always_comb begin
		is_new    = !hit_q;
		room      = (cnt_q != CW'(MAX_DISTINCT));
		keep_w    = is_new && room;
		ovf_w     = is_new && !room;
		cnt_nxt   = keep_w ? (cnt_q + CW'(1)) : cnt_q;
		kept_wide = {{sdr_pkg::KEPT_W{1'b0}}, cnt_nxt};
	end

	// Value table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && keep_w) begin
			mem[cnt_q[AW-1:0]] <= val_q;
		end
		if (issue) begin
			rd_q <= mem[idx_q[AW-1:0]];
		end
	end

	// Scan control and distinct count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
			hit_q    <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cmd.load_in) begin
				idx_q    <= '0;
				rd_vld_q <= 1'b0;
				hit_q    <= 1'b0;
			end else if (cmd.scan_en) begin
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				rd_vld_q <= issue;
				if (rd_vld_q && (rd_q == val_q)) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				cnt_q <= last_q ? '0 : cnt_nxt;
			end
		end
	end

	// Captured input and result payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			val_q  <= in_data.value;
			last_q <= in_data.last;
		end
		if (cmd.commit) begin
			out_q.value_out    <= val_q;
			out_q.keep         <= keep_w;
			out_q.kept_count   <= kept_wide[sdr_pkg::KEPT_W-1:0];
			out_q.overflow     <= ovf_w;
			out_q.end_of_array <= last_q;
		end
	end

	assign out_data = out_q;

	`SDR_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(MAX_DISTINCT), "count beyond table size")
	`SDR_ASSERT_NOW(a_idx_bound, clk, arst_n, cmd.scan_en, idx_q <= cnt_q,
		"scan index beyond stored count")
	`SDR_ASSERT_NXT(a_last_clr, clk, arst_n, cmd.commit && last_q, cnt_q == '0, "count not cleared after last element")

endmodule

/* hw/rtl/sdr_ctrl.sv */
// Controller: accept, scan and commit sequencing plus output valid
`include "stream_duplicate_remover_macros.svh"

module sdr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sdr_pkg::sdr_sts_t sts,
	output sdr_pkg::sdr_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_vld_q;
	logic   out_free;

	// Result register can take a new result when empty or being drained
	assign out_free = !out_vld_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_nxt   = state_q;
		cmd.load_in = 1'b0;
		cmd.scan_en = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_done) begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;

	`SDR_ASSERT_NXT(a_commit_shows, clk, arst_n, cmd.commit, out_valid, "committed result not presented")
	`SDR_ASSERT_NXT(a_load_scans, clk, arst_n, cmd.load_in, state_q == ST_SCAN, "accepted element did not start a scan")

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the stream duplicate remover: directed arrays, full table, random arrays
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W = sdr_pkg::DATA_W;
	localparam int KEPT_W = sdr_pkg::KEPT_W;
	localparam int MAX_DISTINCT = 256;
	localparam logic [DATA_W-1:0] FILL_STRIDE = 32'h9E37_79B1;
	localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

	typedef enum int {
		SINK_OPEN,
		SINK_RANDOM,
		SINK_PERIODIC,
		SINK_SPARSE
	} sink_mode_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	sdr_pkg::sdr_in_t  in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	sdr_pkg::sdr_out_t out_data;

	// Shadow of the distinct-value table
	logic [DATA_W-1:0] shadow_values [MAX_DISTINCT];
	int                shadow_count = 0;

	sdr_pkg::sdr_out_t expected_results [$];

	int items_sent      = 0;
	int results_checked = 0;
	int kept_total      = 0;
	int dup_total       = 0;
	int overflow_total  = 0;
	int arrays_total    = 0;
	int mismatch_count  = 0;
	int burst_left      = 0;

	sink_mode_t sink_mode  = SINK_OPEN;
	int         sink_left  = 0;
	int         sink_phase = 0;

	stream_duplicate_remover #(
		.MAX_DISTINCT(MAX_DISTINCT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	// Hard stop if the run hangs
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Linear search of the shadow table
	function automatic logic table_has(input logic [DATA_W-1:0] v);
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_values[i] == v)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Keep-first decision for one element, updating the shadow table
	function automatic sdr_pkg::sdr_out_t predict_result(input sdr_pkg::sdr_in_t item);
		sdr_pkg::sdr_out_t r;
		r = '0;
		if (!table_has(item.value)) begin
			if (shadow_count < MAX_DISTINCT) begin
				shadow_values[shadow_count] = item.value;
				shadow_count++;
				r.keep = 1'b1;
			end else begin
				r.overflow = 1'b1;
			end
		end
		r.value_out    = item.value;
		r.kept_count   = KEPT_W'(shadow_count);
		r.end_of_array = item.last;
		if (item.last)
			shadow_count = 0;
		return r;
	endfunction

	// Value mix biased towards extremes and small numbers
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return INT_MIN;
			2: return INT_MAX;
			3: return -1;
			4: return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
			default: return $urandom;
		endcase
	endfunction

	// One input transfer, with burst/gap pacing in front of it
	task automatic send_element(input logic signed [DATA_W-1:0] v, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(20, 60);
				default: gap = $urandom_range(1, 6);
			endcase
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= '{value: v, last: is_last};
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_result(in_data));
		items_sent++;
		burst_left--;
		if (is_last)
			arrays_total++;
	endtask

	// Hold the input off until every expected result has been seen
	task automatic drain_results();
		in_valid  <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic report_field(input string name, input logic [DATA_W-1:0] want_v,
			input logic [DATA_W-1:0] got_v);
		if (want_v !== got_v) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch in %s at result %0d: expected %h, got %h",
					name, results_checked, want_v, got_v);
		end
	endtask

	// Receiver stall pattern, switching among open, random, periodic and sparse modes
	always @(posedge clk) begin : sink_pattern
		if (sink_left == 0) begin
			sink_mode  = sink_mode_t'($urandom_range(0, 3));
			sink_left  = $urandom_range(50, 400);
			sink_phase = 0;
		end
		sink_left--;
		case (sink_mode)
			SINK_OPEN:     out_ready <= 1'b1;
			SINK_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
			SINK_PERIODIC: out_ready <= ((sink_phase % 7) < 3);
			default:       out_ready <= ($urandom_range(0, 4) == 0);
		endcase
		sink_phase++;
	end

	// Compare each output transfer with the oldest expectation
	always @(posedge clk) begin : result_check
		sdr_pkg::sdr_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %h with nothing pending", out_data);
			end else begin
				want = expected_results.pop_front();
				report_field("value_out", want.value_out, out_data.value_out);
				report_field("keep", DATA_W'(want.keep), DATA_W'(out_data.keep));
				report_field("kept_count", DATA_W'(want.kept_count),
					DATA_W'(out_data.kept_count));
				report_field("overflow", DATA_W'(want.overflow), DATA_W'(out_data.overflow));
				report_field("end_of_array", DATA_W'(want.end_of_array),
					DATA_W'(out_data.end_of_array));
				if (want.keep)
					kept_total++;
				else if (want.overflow)
					overflow_total++;
				else
					dup_total++;
			end
			results_checked++;
		end
	end

	// Extremes of the value range, duplicates of them, last on a duplicate
	task automatic test_extreme_values();
		send_element(INT_MIN, 1'b0);
		send_element(INT_MAX, 1'b0);
		send_element(-1, 1'b0);
		send_element(1, 1'b0);
		send_element(32'sh5555_5555, 1'b0);
		send_element(32'shAAAA_AAAA, 1'b0);
		send_element(INT_MIN, 1'b0);
		send_element(-1, 1'b0);
		send_element(INT_MAX, 1'b1);
	endtask

	// Zero follows the keep-first rule like any other value
	task automatic test_zero_is_ordinary();
		send_element(0, 1'b0);
		send_element(0, 1'b0);
		send_element(7, 1'b0);
		send_element(0, 1'b0);
		send_element(0, 1'b1);
	endtask

	// One-element arrays; the table must be empty again each time
	task automatic test_single_element_arrays();
		send_element(0, 1'b1);
		send_element(0, 1'b1);
		send_element(INT_MIN, 1'b1);
	endtask

	// Fill the table, then new values meet a full table
	task automatic test_table_full();
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] v;
		base = $urandom;
		// odd stride keeps every fill value distinct
		for (int i = 0; i < MAX_DISTINCT; i++) begin
			send_element(base + DATA_W'(i) * FILL_STRIDE, 1'b0);
			if (i % 64 == 63)
				send_element(base, 1'b0);
		end
		for (int i = 0; i < 4; i++) begin
			do v = $urandom; while (table_has(v));
			send_element(v, 1'b0);
		end
		send_element(base + DATA_W'(5) * FILL_STRIDE, 1'b0);
		do v = $urandom; while (table_has(v));
		send_element(v, 1'b1);
		// next array starts from an empty table
		send_element(base, 1'b0);
		send_element(base + FILL_STRIDE, 1'b1);
	endtask

	// Random arrays drawn from small pools so duplicates are common
	task automatic test_random_arrays(input int n_items);
		logic signed [DATA_W-1:0] pool [32];
		logic signed [DATA_W-1:0] v;
		int target;
		int len;
		int pool_size;
		int all_fresh;
		target = items_sent + n_items;
		while (items_sent < target) begin
			len       = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
				: $urandom_range(1, 24);
			pool_size = $urandom_range(1, 32);
			all_fresh = ($urandom_range(0, 7) == 0);
			for (int i = 0; i < pool_size; i++)
				pool[i] = pick_value();
			for (int i = 0; i < len; i++) begin
				if (all_fresh || $urandom_range(0, 15) == 0)
					v = $urandom;
				else
					v = pool[$urandom_range(0, pool_size - 1)];
				send_element(v, i == len - 1);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_extreme_values();
		test_zero_is_ordinary();
		test_single_element_arrays();
		drain_results();
		test_table_full();
		drain_results();
		test_random_arrays(410);
		drain_results();
		test_random_arrays(410);
		drain_results();

		// let any stray result surface
		repeat (MAX_DISTINCT + 8) @(posedge clk);

		$display("Sent %0d elements in %0d arrays; checked %0d results.",
			items_sent, arrays_total, results_checked);
		$display("Outcomes: %0d kept, %0d duplicates, %0d full-table rejects, %0d mismatches.",
			kept_total, dup_total, overflow_total, mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sdr_pkg.sv
hw/rtl/sdr_datapath.sv
hw/rtl/sdr_ctrl.sv
hw/rtl/stream_duplicate_remover.sv
sim/tb_top.sv
